FILE: src/mfle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfle_pkg: shared types and constants for the meter frame link engine
// Item and result layouts, the job passed from front to back, frame codes.
// ----------------------------------------------------------------------------
package mfle_pkg;

	localparam int FRAME_BYTES = 7;
	localparam logic [2:0] LAST_IDX = 3'(FRAME_BYTES - 1);

	// cmd codes
	localparam logic [1:0] CMD_RX   = 2'd0;
	localparam logic [1:0] CMD_SEND = 2'd1;
	localparam logic [1:0] CMD_POLL = 2'd2;

	// request / reply kinds
	localparam logic [2:0] KIND_VOLTAGE = 3'd0;
	localparam logic [2:0] KIND_CURRENT = 3'd1;
	localparam logic [2:0] KIND_POWER   = 3'd2;
	localparam logic [2:0] KIND_ENERGY  = 3'd3;
	localparam logic [2:0] KIND_ADDRESS = 3'd4;
	localparam logic [2:0] KIND_ALARM   = 3'd5;

	// reply frame status
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_CHECKSUM = 2'd1;
	localparam logic [1:0] ST_HEADER   = 2'd2;

	localparam logic [7:0] REQ_BASE = 8'hB0;
	localparam logic [7:0] RSP_BASE = 8'hA0;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  rx_byte;
		logic [2:0]  req_kind;
		logic [31:0] req_address;
		logic [7:0]  req_data;
	} item_t;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        tx_last;
		logic        frame_valid;
		logic [1:0]  frame_status;
		logic [2:0]  frame_kind;
		logic [23:0] reading;
		logic        reply_accepted;
		logic [31:0] device_address;
		logic [7:0]  alarm_threshold;
	} result_t;

	// one classified piece of work for the back end
	typedef struct packed {
		logic        is_tx;
		logic [7:0]  code;
		logic [31:0] addr;
		logic [7:0]  data;
		logic [7:0]  chk;
		logic [1:0]  status;
		logic [2:0]  kind;
		logic [7:0]  d0;
		logic [7:0]  d1;
		logic [7:0]  d2;
		logic        accepted;
		logic [31:0] dev_addr;
		logic [7:0]  thr;
	} job_t;

endpackage

FILE: src/mfle_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfle_front: item intake and classification
// Collects reply bytes, checks and commits acknowledgements, builds request
// frames, and hands one job per result-producing item to the queue.
// ----------------------------------------------------------------------------
module mfle_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             acc,
	input  mfle_pkg::item_t  item,
	output logic             job_push,
	output mfle_pkg::job_t   job
);

	logic [2:0]  rx_count_q;
	logic [7:0]  rx_frame_q [6];
	logic [7:0]  rx_sum_q;
	logic [31:0] conf_addr_q;
	logic [31:0] pend_addr_q;
	logic [7:0]  pend_thr_q;
	logic [7:0]  conf_thr_q;
	logic [1:0]  next_poll_q;

	logic [2:0]  rx_count_d;
	logic [7:0]  rx_sum_d;
	logic [31:0] conf_addr_d;
	logic [31:0] pend_addr_d;
	logic [7:0]  pend_thr_d;
	logic [7:0]  conf_thr_d;
	logic [1:0]  next_poll_d;
	logic        frame_wr;

	logic [7:0]  hdr_off;
	logic        zero5;
	logic        addr_ok;
	logic [7:0]  tx_code;
	logic [31:0] tx_addr;
	logic [7:0]  tx_data;

	assign hdr_off = rx_frame_q[0] - mfle_pkg::RSP_BASE;
	assign zero5 = (rx_frame_q[1] | rx_frame_q[2] | rx_frame_q[3] | rx_frame_q[4]
		| rx_frame_q[5]) == 8'h00;
	assign addr_ok = (conf_addr_q[31:24] != 8'h00) && (conf_addr_q[23:16] != 8'h00)
		&& (conf_addr_q[15:8] != 8'h00) && (conf_addr_q[7:0] != 8'h00);

	always_comb begin
		rx_count_d  = rx_count_q;
		rx_sum_d    = rx_sum_q;
		conf_addr_d = conf_addr_q;
		pend_addr_d = pend_addr_q;
		pend_thr_d  = pend_thr_q;
		conf_thr_d  = conf_thr_q;
		next_poll_d = next_poll_q;
		frame_wr    = 1'b0;
		job_push    = 1'b0;
		tx_code     = {5'b0, item.req_kind} + mfle_pkg::REQ_BASE;
		tx_addr     = item.req_address;
		tx_data     = item.req_data;
		job         = '0;
		case (item.cmd)
			mfle_pkg::CMD_RX: begin
				if (rx_count_q == mfle_pkg::LAST_IDX) begin
					// seventh byte: checksum, header check, decode
					job_push   = 1'b1;
					rx_count_d = '0;
					rx_sum_d   = '0;
					if (item.rx_byte != rx_sum_q) begin
						job.status = mfle_pkg::ST_CHECKSUM;
					end else if (hdr_off > 8'(mfle_pkg::KIND_ALARM)) begin
						job.status = mfle_pkg::ST_HEADER;
					end else begin
						job.status = mfle_pkg::ST_OK;
						job.kind   = hdr_off[2:0];
						if (hdr_off[2:0] == mfle_pkg::KIND_ADDRESS) begin
							if (zero5) begin
								conf_addr_d  = pend_addr_q;
								job.accepted = 1'b1;
							end else begin
								pend_addr_d = '0;
							end
						end else if (hdr_off[2:0] == mfle_pkg::KIND_ALARM) begin
							if (zero5) begin
								conf_thr_d   = pend_thr_q;
								job.accepted = 1'b1;
							end else begin
								pend_thr_d = '0;
							end
						end
					end
				end else if (!(rx_count_q == 3'd0 && item.rx_byte == 8'h00)) begin
					frame_wr   = 1'b1;
					rx_sum_d   = rx_sum_q + item.rx_byte;
					rx_count_d = rx_count_q + 3'd1;
				end
			end
			mfle_pkg::CMD_SEND: begin
				if (item.req_kind <= mfle_pkg::KIND_ALARM) begin
					job_push = 1'b1;
					job.is_tx = 1'b1;
					if (item.req_kind == mfle_pkg::KIND_ADDRESS) begin
						pend_addr_d = item.req_address;
					end else if (item.req_kind == mfle_pkg::KIND_ALARM) begin
						pend_thr_d = item.req_data;
					end
				end
			end
			mfle_pkg::CMD_POLL: begin
				tx_code = {6'b0, next_poll_q} + mfle_pkg::REQ_BASE;
				tx_addr = conf_addr_q;
				tx_data = 8'h00;
				if (addr_ok) begin
					job_push    = 1'b1;
					job.is_tx   = 1'b1;
					next_poll_d = next_poll_q + 2'd1;
				end
			end
			default: begin
			end
		endcase
		job.code = tx_code;
		job.addr = tx_addr;
		job.data = tx_data;
		job.chk  = tx_code + tx_addr[31:24] + tx_addr[23:16] + tx_addr[15:8]
			+ tx_addr[7:0] + tx_data;
		job.d0   = rx_frame_q[1];
		job.d1   = rx_frame_q[2];
		job.d2   = rx_frame_q[3];
		job.dev_addr = conf_addr_d;
		job.thr      = conf_thr_d;
		job_push = job_push & acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_count_q  <= '0;
			rx_sum_q    <= '0;
			conf_addr_q <= '0;
			pend_addr_q <= '0;
			pend_thr_q  <= '0;
			conf_thr_q  <= '0;
			next_poll_q <= '0;
		end else if (acc) begin
			rx_count_q  <= rx_count_d;
			rx_sum_q    <= rx_sum_d;
			conf_addr_q <= conf_addr_d;
			pend_addr_q <= pend_addr_d;
			pend_thr_q  <= pend_thr_d;
			conf_thr_q  <= conf_thr_d;
			next_poll_q <= next_poll_d;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && frame_wr) begin
			rx_frame_q[rx_count_q] <= item.rx_byte;
		end
	end

endmodule

FILE: src/mfle_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfle_queue: short job queue between front and back
// Register-based FIFO; push blocked while full, pop while empty is ignored.
// ----------------------------------------------------------------------------
module mfle_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  mfle_pkg::job_t  wr_job,
	input  logic            rd,
	output logic            full,
	output logic            valid,
	output mfle_pkg::job_t  head
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mfle_pkg::job_t   slot_q [DEPTH];
	logic [IDX_W-1:0] wr_ptr_q;
	logic [IDX_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = cnt_q == CNT_W'(DEPTH);
	assign valid = cnt_q != '0;
	assign head  = slot_q[rd_ptr_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

FILE: src/mfle_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfle_back: result sequencer
// Serializes request jobs into seven frame bytes, decodes reply jobs into
// readings, and holds each result in an output register until popped.
// ----------------------------------------------------------------------------
module mfle_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  mfle_pkg::job_t    q_head,
	output logic              q_pop,
	input  logic              pop,
	output logic              empty,
	output mfle_pkg::result_t result
);

	logic [2:0]         idx_q;
	logic               out_valid_q;
	mfle_pkg::result_t  result_q;
	mfle_pkg::result_t  res_d;
	logic               load;
	logic               take;
	logic               last_byte;
	logic [15:0]        whole;

	assign load      = !out_valid_q || pop;
	assign take      = load && q_valid;
	assign last_byte = idx_q == mfle_pkg::LAST_IDX;
	assign q_pop     = take && (!q_head.is_tx || last_byte);
	assign whole     = {q_head.d0, q_head.d1};

	always_comb begin
		res_d = '0;
		res_d.device_address  = q_head.dev_addr;
		res_d.alarm_threshold = q_head.thr;
		if (q_head.is_tx) begin
			res_d.tx_valid = 1'b1;
			res_d.tx_last  = last_byte;
			case (idx_q)
				3'd0:    res_d.tx_byte = q_head.code;
				3'd1:    res_d.tx_byte = q_head.addr[31:24];
				3'd2:    res_d.tx_byte = q_head.addr[23:16];
				3'd3:    res_d.tx_byte = q_head.addr[15:8];
				3'd4:    res_d.tx_byte = q_head.addr[7:0];
				3'd5:    res_d.tx_byte = q_head.data;
				default: res_d.tx_byte = q_head.chk;
			endcase
		end else begin
			res_d.frame_valid    = 1'b1;
			res_d.frame_status   = q_head.status;
			res_d.frame_kind     = q_head.kind;
			res_d.reply_accepted = q_head.accepted;
			if (q_head.status == mfle_pkg::ST_OK) begin
				unique case (q_head.kind)
					mfle_pkg::KIND_VOLTAGE:
						res_d.reading = 24'(whole) * 24'd10 + 24'(q_head.d2);
					mfle_pkg::KIND_CURRENT:
						res_d.reading = 24'(whole) * 24'd100 + 24'(q_head.d2);
					mfle_pkg::KIND_POWER:
						res_d.reading = 24'(whole);
					mfle_pkg::KIND_ENERGY:
						res_d.reading = {q_head.d0, q_head.d1, q_head.d2};
					default:
						res_d.reading = '0;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= q_valid;
			end
			if (take && q_head.is_tx) begin
				idx_q <= last_byte ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= res_d;
		end
	end

	assign empty  = !out_valid_q;
	assign result = result_q;

endmodule

FILE: src/meter_frame_link_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meter_frame_link_engine: serial meter request/reply link engine
// Builds seven-byte request frames and checks and decodes reply frames.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive item with push; an item is taken when push is high and
//   full is low. cmd selects a received byte, an explicit request or a poll.
//   Result queue: while empty is low, result holds the oldest result; pop
//   takes it. A request of kind up to alarm, or a poll while the confirmed
//   address has no zero byte, yields seven results (frame bytes, the last
//   flagged tx_last); the seventh byte of a reply yields one decoded result;
//   other items yield none. An item's job enters the job queue, and its
//   first result is loaded into the output register once that is free.
//   Throughput: one item per cycle into the front while full is low; the
//   back drains one result per cycle while pop is high, so a request frame
//   holds the back until all seven of its bytes are taken. The job queue
//   (QUEUE_DEPTH entries) sets how far the front runs ahead before full rises.
//   Reset clears the queue, the output register, reply assembly, addresses,
//   thresholds and the poll rotation (next poll asks for voltage).
//   A stalled receiver keeps the current result in place; the queue fills and
//   then full holds off new items.
// ----------------------------------------------------------------------------
module meter_frame_link_engine #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  mfle_pkg::item_t   item,
	output logic              empty,
	input  logic              pop,
	output mfle_pkg::result_t result
);

	logic            acc;
	logic            job_push;
	mfle_pkg::job_t  job;
	logic            q_valid;
	logic            q_pop;
	mfle_pkg::job_t  q_head;

	assign acc = push && !full;

	mfle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.item     (item),
		.job_push (job_push),
		.job      (job)
	);

	mfle_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_push),
		.wr_job (job),
		.rd     (q_pop),
		.full   (full),
		.valid  (q_valid),
		.head   (q_head)
	);

	mfle_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(q_valid),
		.q_head (q_head),
		.q_pop  (q_pop),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

	// a result is either a frame byte or a reply report, never both
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(result.tx_valid && result.frame_valid))
		else $error("result carries both a tx byte and a reply report");

	a_last_is_tx: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.tx_last |-> result.tx_valid)
		else $error("tx_last without tx_valid");

	a_accept_ok: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.reply_accepted |->
			result.frame_valid && result.frame_status == mfle_pkg::ST_OK)
		else $error("acknowledgement accepted on a bad frame");

	// a byte taken mid-frame must be followed by the next byte of that frame
	a_frame_cont: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && result.tx_valid && !result.tx_last |=>
			!empty && result.tx_valid)
		else $error("request frame broken off before its checksum byte");

endmodule

FILE: verif/meter_frame_link_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meter_frame_link_engine_tb: self-checking bench for the meter link engine
// Drives explicit requests, polls and received reply bytes through the input
// queue with random gaps. A behavioral predictor builds the expected frame
// bytes and decoded replies. Every popped result is compared field by field.
// ----------------------------------------------------------------------------
module meter_frame_link_engine_tb;

	localparam logic [1:0] CMD_SPARE     = 2'd3;
	localparam logic [2:0] KIND_SPARE_LO = 3'd6;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;
	localparam int ITEM_TARGET   = 310;
	localparam int MAX_WAIT      = 8;
	localparam int SETTLE_CYCLES = 16;
	localparam int REPORT_LIMIT  = 10;

	logic              clk;
	logic              arst_n;
	logic              push;
	logic              full;
	mfle_pkg::item_t   item;
	logic              empty;
	logic              pop;
	mfle_pkg::result_t result;

	// predictor state
	int unsigned rx_fill   = 0;
	logic [7:0]  rx_hold [6];
	logic [7:0]  rx_acc    = '0;
	logic [31:0] addr_conf = '0;
	logic [31:0] addr_pend = '0;
	logic [7:0]  thr_pend  = '0;
	logic [7:0]  thr_conf  = '0;
	logic [1:0]  poll_next = '0;

	mfle_pkg::result_t link_results_q[$];
	int      n_mismatch   = 0;
	int      n_link_items = 0;
	bit      send_quiet   = 1'b0;
	bit      pop_quiet    = 1'b0;

	meter_frame_link_engine u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------- predictor ----------------

	function automatic void queue_tx_frame(logic [7:0] code, logic [31:0] addr,
			logic [7:0] data);
		logic [7:0] fb [mfle_pkg::FRAME_BYTES];
		logic [7:0] sum;
		mfle_pkg::result_t r;
		int         i;
		fb[0] = code;
		fb[1] = addr[31:24];
		fb[2] = addr[23:16];
		fb[3] = addr[15:8];
		fb[4] = addr[7:0];
		fb[5] = data;
		sum = '0;
		for (i = 0; i < mfle_pkg::FRAME_BYTES - 1; i++)
			sum += fb[i];
		fb[mfle_pkg::FRAME_BYTES - 1] = sum;
		for (i = 0; i < mfle_pkg::FRAME_BYTES; i++) begin
			r = '0;
			r.tx_valid        = 1'b1;
			r.tx_byte         = fb[i];
			r.tx_last         = (i == mfle_pkg::FRAME_BYTES - 1);
			r.device_address  = addr_conf;
			r.alarm_threshold = thr_conf;
			link_results_q.push_back(r);
		end
	endfunction

	function automatic void decode_reply(logic [7:0] chk);
		mfle_pkg::result_t r;
		logic [15:0] word;
		logic [31:0] val;
		logic        all_zero;
		r        = '0;
		val      = '0;
		word     = {rx_hold[1], rx_hold[2]};
		all_zero = (rx_hold[1] | rx_hold[2] | rx_hold[3] | rx_hold[4] | rx_hold[5]) == 8'd0;
		if (chk != rx_acc) begin
			r.frame_status = mfle_pkg::ST_CHECKSUM;
		end else if (rx_hold[0] < mfle_pkg::RSP_BASE
				|| rx_hold[0] > mfle_pkg::RSP_BASE + 8'd5) begin
			r.frame_status = mfle_pkg::ST_HEADER;
		end else begin
			r.frame_status = mfle_pkg::ST_OK;
			r.frame_kind   = 3'(rx_hold[0] - mfle_pkg::RSP_BASE);
			case (r.frame_kind)
				mfle_pkg::KIND_VOLTAGE: val = 32'(word) * 32'd10 + 32'(rx_hold[3]);
				mfle_pkg::KIND_CURRENT: val = 32'(word) * 32'd100 + 32'(rx_hold[3]);
				mfle_pkg::KIND_POWER:   val = 32'(word);
				mfle_pkg::KIND_ENERGY:  val = {8'd0, word, rx_hold[3]};
				mfle_pkg::KIND_ADDRESS: begin
					if (all_zero) begin
						addr_conf        = addr_pend;
						r.reply_accepted = 1'b1;
					end else begin
						addr_pend = '0;
					end
				end
				default: begin
					if (all_zero) begin
						thr_conf         = thr_pend;
						r.reply_accepted = 1'b1;
					end else begin
						thr_pend = '0;
					end
				end
			endcase
		end
		r.frame_valid     = 1'b1;
		r.reading         = val[23:0];
		r.device_address  = addr_conf;
		r.alarm_threshold = thr_conf;
		rx_fill = 0;
		rx_acc  = '0;
		link_results_q.push_back(r);
	endfunction

	// returns 0 when the engine is expected to ignore the item outright
	function automatic bit predict_link_item(mfle_pkg::item_t it);
		bit live;
		live = 1'b1;
		case (it.cmd)
			mfle_pkg::CMD_RX: begin
				if (rx_fill == 0 && it.rx_byte == 8'd0) begin
					live = 1'b0;
				end else if (rx_fill >= mfle_pkg::FRAME_BYTES - 1) begin
					decode_reply(it.rx_byte);
				end else begin
					rx_hold[rx_fill] = it.rx_byte;
					rx_acc += it.rx_byte;
					rx_fill++;
				end
			end
			mfle_pkg::CMD_SEND: begin
				if (it.req_kind > mfle_pkg::KIND_ALARM) begin
					live = 1'b0;
				end else begin
					if (it.req_kind == mfle_pkg::KIND_ADDRESS)
						addr_pend = it.req_address;
					else if (it.req_kind == mfle_pkg::KIND_ALARM)
						thr_pend = it.req_data;
					queue_tx_frame(mfle_pkg::REQ_BASE + 8'(it.req_kind), it.req_address,
						it.req_data);
				end
			end
			mfle_pkg::CMD_POLL: begin
				if (addr_conf[31:24] == 8'd0 || addr_conf[23:16] == 8'd0 ||
						addr_conf[15:8] == 8'd0 || addr_conf[7:0] == 8'd0) begin
					live = 1'b0;
				end else begin
					queue_tx_frame(mfle_pkg::REQ_BASE + 8'(poll_next), addr_conf, 8'd0);
					poll_next++;
				end
			end
			default: live = 1'b0;
		endcase
		return live;
	endfunction

	// ---------------- checking ----------------

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			n_mismatch++;
			if (n_mismatch <= REPORT_LIMIT)
				$display("mismatch on %s: expected %0h, got %0h", name, want, got);
		end
	endfunction

	function automatic void check_result(mfle_pkg::result_t got);
		mfle_pkg::result_t want;
		if (link_results_q.size() == 0) begin
			n_mismatch++;
			if (n_mismatch <= REPORT_LIMIT)
				$display("unexpected result %h with nothing expected", got);
		end else begin
			want = link_results_q.pop_front();
			check_field("tx_valid", 32'(want.tx_valid), 32'(got.tx_valid));
			check_field("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
			check_field("tx_last", 32'(want.tx_last), 32'(got.tx_last));
			check_field("frame_valid", 32'(want.frame_valid), 32'(got.frame_valid));
			check_field("frame_status", 32'(want.frame_status), 32'(got.frame_status));
			check_field("frame_kind", 32'(want.frame_kind), 32'(got.frame_kind));
			check_field("reading", 32'(want.reading), 32'(got.reading));
			check_field("reply_accepted", 32'(want.reply_accepted),
				32'(got.reply_accepted));
			check_field("device_address", want.device_address, got.device_address);
			check_field("alarm_threshold", 32'(want.alarm_threshold),
				32'(got.alarm_threshold));
		end
	endfunction

	initial begin : result_checker
		int stall;
		stall = 0;
		pop   = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
			end
			@(posedge clk);
			if (pop && !empty) begin
				check_result(result);
				if ($urandom_range(0, 23) == 0)
					pop_quiet = !pop_quiet;
				stall = pop_quiet ? 0 : $urandom_range(0, MAX_WAIT);
			end
		end
	end

	// ---------------- stimulus helpers ----------------

	// don't-care fields carry random values so every input bit toggles
	function automatic mfle_pkg::item_t random_item();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(mfle_pkg::item_t)-1:0];
	endfunction

	function automatic logic [31:0] rand_address();
		logic [31:0] a;
		int          sel;
		sel = $urandom_range(0, 9);
		a = {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
			8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
		if (sel == 0)
			a = '1;
		else if (sel == 1)
			a[8 * $urandom_range(0, 3) +: 8] = 8'd0;
		else if (sel == 2)
			a = $urandom;
		return a;
	endfunction

	function automatic logic [39:0] random_payload();
		int sel;
		sel = $urandom_range(0, 5);
		if (sel == 0)
			return '1;
		else if (sel == 1)
			return '0;
		return {$urandom, 8'($urandom)};
	endfunction

	task automatic send_item(mfle_pkg::item_t it);
		int gap;
		if ($urandom_range(0, 23) == 0)
			send_quiet = !send_quiet;
		gap = send_quiet ? 0 : $urandom_range(0, MAX_WAIT);
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		void'(predict_link_item(it));
		n_link_items++;
	endtask

	task automatic send_rx(logic [7:0] b);
		mfle_pkg::item_t it;
		it = random_item();
		it.cmd     = mfle_pkg::CMD_RX;
		it.rx_byte = b;
		send_item(it);
	endtask

	task automatic send_request(logic [2:0] kind, logic [31:0] addr, logic [7:0] data);
		mfle_pkg::item_t it;
		it = random_item();
		it.cmd         = mfle_pkg::CMD_SEND;
		it.req_kind    = kind;
		it.req_address = addr;
		it.req_data    = data;
		send_item(it);
	endtask

	task automatic send_poll();
		mfle_pkg::item_t it;
		it = random_item();
		it.cmd = mfle_pkg::CMD_POLL;
		send_item(it);
	endtask

	task automatic send_spare();
		mfle_pkg::item_t it;
		it = random_item();
		it.cmd = CMD_SPARE;
		send_item(it);
	endtask

	// first closes any partial frame so the new one lines up
	task automatic send_reply_frame(logic [7:0] hdr, logic [39:0] payload, bit corrupt,
			bit lead);
		logic [7:0] sum;
		logic [7:0] fb;
		int         i;
		while (rx_fill != 0)
			send_rx(8'($urandom_range(1, 255)));
		if (lead)
			repeat ($urandom_range(1, 2)) send_rx(8'd0);
		send_rx(hdr);
		sum = hdr;
		for (i = 4; i >= 0; i--) begin
			fb = payload[i * 8 +: 8];
			sum += fb;
			send_rx(fb);
		end
		if (corrupt)
			sum ^= 8'($urandom_range(1, 255));
		send_rx(sum);
	endtask

	task automatic await_idle();
		@(negedge clk);
		push <= 1'b0;
		while (link_results_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ---------------- tests ----------------

	task automatic test_explicit_requests();
		send_request(mfle_pkg::KIND_VOLTAGE, 32'h0000_0000, 8'h00);
		send_request(mfle_pkg::KIND_CURRENT, 32'hFFFF_FFFF, 8'hFF);
		send_request(mfle_pkg::KIND_POWER, 32'h0102_0304, 8'h80);
		send_request(mfle_pkg::KIND_ENERGY, $urandom, 8'($urandom));
		send_request(KIND_SPARE_LO, $urandom, 8'($urandom));
		send_request(KIND_SPARE_HI, $urandom, 8'($urandom));
		send_spare();
		// no address confirmed yet, poll is dropped
		send_poll();
		send_request(mfle_pkg::KIND_ALARM, 32'hFF00_FF00, 8'hFF);
		send_request(mfle_pkg::KIND_ADDRESS, 32'hC3A5_5A01, 8'h00);
	endtask

	task automatic test_address_commit();
		send_rx(8'd0);
		send_reply_frame(mfle_pkg::RSP_BASE + 8'(mfle_pkg::KIND_ADDRESS), 40'h0, 1'b0, 1'b0);
		send_poll();
	endtask

	task automatic test_reading_extremes();
		send_reply_frame(mfle_pkg::RSP_BASE + 8'(mfle_pkg::KIND_CURRENT), '1, 1'b0, 1'b0);
	endtask

	task automatic test_random_traffic();
		int          pick;
		logic [7:0]  hdr;
		logic [39:0] ack;
		while (n_link_items < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			ack  = ($urandom_range(0, 3) != 0) ? 40'h0 : {$urandom, 8'($urandom)};
			if (pick < 30) begin
				hdr = ($urandom_range(0, 4) != 0)
					? mfle_pkg::RSP_BASE + 8'($urandom_range(0, 5))
					: 8'($urandom_range(1, 255));
				send_reply_frame(hdr, random_payload(), $urandom_range(0, 7) == 0,
					$urandom_range(0, 3) == 0);
			end else if (pick < 45) begin
				send_request(3'($urandom_range(0, 7)), rand_address(), 8'($urandom));
			end else if (pick < 60) begin
				send_poll();
			end else if (pick < 70) begin
				send_request(mfle_pkg::KIND_ADDRESS, rand_address(), 8'($urandom));
				send_reply_frame(mfle_pkg::RSP_BASE + 8'(mfle_pkg::KIND_ADDRESS), ack,
					$urandom_range(0, 9) == 0, $urandom_range(0, 3) == 0);
			end else if (pick < 78) begin
				send_request(mfle_pkg::KIND_ALARM, rand_address(), 8'($urandom));
				send_reply_frame(mfle_pkg::RSP_BASE + 8'(mfle_pkg::KIND_ALARM), ack,
					$urandom_range(0, 9) == 0, $urandom_range(0, 3) == 0);
			end else if (pick < 92) begin
				repeat ($urandom_range(1, 4))
					send_rx(($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom));
			end else if (pick < 96) begin
				send_spare();
			end else begin
				send_request(($urandom_range(0, 1) == 0) ? KIND_SPARE_LO : KIND_SPARE_HI,
					$urandom, 8'($urandom));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push   = 1'b0;
		item   = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_explicit_requests();
		await_idle();
		test_address_commit();
		await_idle();
		test_reading_extremes();
		await_idle();
		test_random_traffic();
		await_idle();
		if (n_mismatch == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// run limit, far beyond the slowest legal run
	initial begin
		#1_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
